@@ src/nrc_pkg.sv @@
`timescale 1ns / 1ps

package nrc_pkg;

   localparam int MAX_STRAINS = 8;
   localparam int MAX_LOCI    = 64;

   localparam int STR_W  = (MAX_STRAINS > 1) ? $clog2(MAX_STRAINS) : 1;
   localparam int LOCI_W = $clog2(MAX_LOCI);
   localparam int POS_W  = $clog2(MAX_LOCI + 1);

   localparam int BASE_W     = 8;
   localparam int CNT_W      = 7;
   localparam int NUM_W      = 4;
   localparam int THR_W      = 7;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;

   localparam logic [CNT_W-1:0]  CNT_MAX   = 7'd127;
   localparam logic [BASE_W-1:0] BASE_N    = 8'd78;
   localparam logic [NUM_W-1:0]  NUM_RESET = 4'd8;
   localparam logic [THR_W-1:0]  THR_RESET = 7'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_STRAINS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD   = 1'b1;

   // one slot of the cell chain
   typedef struct packed {
      logic              valid;
      logic              load;      // reference write
      logic              count;     // read base that takes part in the compare
      logic              last;      // final base of a read
      logic [STR_W-1:0]  strain;
      logic [LOCI_W-1:0] addr;
      logic [BASE_W-1:0] base;
      logic [CNT_W-1:0]  unknown;
      logic              too_long;
      logic [CNT_W-1:0]  best_dist; // running minimum along the chain
      logic [NUM_W-1:0]  best_idx;
   } token_type;

   typedef struct packed {
      logic [NUM_W-1:0] best_strain;
      logic [CNT_W-1:0] best_distance;
      logic [CNT_W-1:0] unknown_count;
      logic             too_long;
   } rsp_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? v : v + CNT_W'(1);
   endfunction

endpackage

@@ src/nearest_reference_classifier_unit.sv @@
`timescale 1ns / 1ps
// Path: a read's last base is registered in the head, then in each strain cell's store-read and
// compare registers, then in the output queue, whose non-empty state drives rsp_valid.
// Throughput: one transaction per cycle while req_stall is low; each strain cell owns one reference
// store port and one counter, and every base visits each cell in turn.
// req_stall rises only while the two-entry output queue is full.
// Reset: synchronous; clears read state and the chain, num_strains = 8, threshold = 2.

module nearest_reference_classifier_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_mode,
   input  logic [2:0]                         req_strain,
   input  logic [5:0]                         req_locus,
   input  logic [7:0]                         req_base,
   input  logic                               req_last,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [3:0]                         rsp_best_strain,
   output logic [6:0]                         rsp_best_distance,
   output logic [6:0]                         rsp_unknown_count,
   output logic                               rsp_too_long,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [nrc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [nrc_pkg::CSR_DATA_W-1:0]     csr_data
);

   logic [nrc_pkg::NUM_W-1:0] num_strains_ff;
   logic [nrc_pkg::THR_W-1:0] threshold_ff;
   logic [nrc_pkg::NUM_W-1:0] num_in_use;

   logic en;
   logic accept;
   logic q_full;
   logic push;

   nrc_pkg::token_type chain [nrc_pkg::MAX_STRAINS+1];
   nrc_pkg::token_type fin_tok;
   nrc_pkg::rsp_type   push_data;
   nrc_pkg::rsp_type   out_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_strains_ff <= nrc_pkg::NUM_RESET;
         threshold_ff   <= nrc_pkg::THR_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            nrc_pkg::CSR_NUM_STRAINS: num_strains_ff <= nrc_pkg::NUM_W'(csr_data);
            nrc_pkg::CSR_THRESHOLD:   threshold_ff   <= nrc_pkg::THR_W'(csr_data);
            default: ;
         endcase
      end
   end

   assign num_in_use = (int'(num_strains_ff) > nrc_pkg::MAX_STRAINS) ?
                       nrc_pkg::NUM_W'(nrc_pkg::MAX_STRAINS) : num_strains_ff;

   assign en        = !q_full;
   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   nrc_head u_head (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .accept     (accept),
      .mode       (req_mode),
      .strain     (req_strain),
      .locus      (req_locus),
      .base       (req_base),
      .last       (req_last),
      .num_in_use (num_in_use),
      .tok_o      (chain[0])
   );

   for (genvar g = 0; g < nrc_pkg::MAX_STRAINS; g++) begin : g_cell
      nrc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .en         (en),
         .cell_idx   (nrc_pkg::STR_W'(g)),
         .num_in_use (num_in_use),
         .tok_i      (chain[g]),
         .tok_o      (chain[g+1])
      );
   end

   always_comb begin
      fin_tok = chain[nrc_pkg::MAX_STRAINS];
      push    = en && fin_tok.valid && !fin_tok.load && fin_tok.last;

      push_data.best_distance = fin_tok.best_dist;
      push_data.unknown_count = fin_tok.unknown;
      push_data.too_long      = fin_tok.too_long;
      // no strain in use, or best too far: recombinant
      if (num_in_use == '0 || fin_tok.best_dist >= threshold_ff) begin
         push_data.best_strain = num_in_use;
      end else begin
         push_data.best_strain = fin_tok.best_idx;
      end
   end

   nrc_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .stall     (rsp_stall),
      .valid     (rsp_valid),
      .data      (out_data),
      .full      (q_full)
   );

   assign rsp_best_strain   = out_data.best_strain;
   assign rsp_best_distance = out_data.best_distance;
   assign rsp_unknown_count = out_data.unknown_count;
   assign rsp_too_long      = out_data.too_long;

endmodule

@@ src/nrc_head.sv @@
`timescale 1ns / 1ps

module nrc_head (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          accept,
   input  logic                          mode,
   input  logic [2:0]                    strain,
   input  logic [5:0]                    locus,
   input  logic [7:0]                    base,
   input  logic                          last,
   input  logic [nrc_pkg::NUM_W-1:0]     num_in_use,
   output nrc_pkg::token_type            tok_o
);

   logic [nrc_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [nrc_pkg::CNT_W-1:0] unk_ff, unk_in;
   logic                      ovf_ff, ovf_in;
   nrc_pkg::token_type        tok_ff, tok_in;

   logic in_range;
   logic is_n;
   logic end_read;

   always_comb begin
      in_range = int'(pos_ff) < nrc_pkg::MAX_LOCI;
      is_n     = (base == nrc_pkg::BASE_N);
      end_read = accept && mode && last;

      pos_in = pos_ff;
      unk_in = unk_ff;
      ovf_in = ovf_ff;
      if (accept && mode) begin
         if (!in_range) begin
            ovf_in = 1'b1;
         end else begin
            pos_in = pos_ff + nrc_pkg::POS_W'(1);
            if (is_n) begin
               unk_in = nrc_pkg::sat_inc(unk_ff);
            end
         end
      end

      tok_in           = '0;
      tok_in.valid     = accept &&
                         (mode || (int'(strain) < nrc_pkg::MAX_STRAINS &&
                                   int'(locus) < nrc_pkg::MAX_LOCI));
      tok_in.load      = !mode;
      tok_in.count     = mode && in_range && !is_n;
      tok_in.last      = mode && last;
      tok_in.strain    = nrc_pkg::STR_W'(strain);
      tok_in.addr      = mode ? nrc_pkg::LOCI_W'(pos_ff) : nrc_pkg::LOCI_W'(locus);
      tok_in.base      = base;
      tok_in.unknown   = unk_in;
      tok_in.too_long  = ovf_in;
      tok_in.best_dist = nrc_pkg::CNT_MAX;
      tok_in.best_idx  = num_in_use;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         unk_ff <= '0;
         ovf_ff <= 1'b0;
         tok_ff <= '0;
      end else if (en) begin
         tok_ff <= tok_in;
         if (end_read) begin
            pos_ff <= '0;
            unk_ff <= '0;
            ovf_ff <= 1'b0;
         end else begin
            pos_ff <= pos_in;
            unk_ff <= unk_in;
            ovf_ff <= ovf_in;
         end
      end
   end

   assign tok_o = tok_ff;

endmodule

@@ src/nrc_cell.sv @@
`timescale 1ns / 1ps

module nrc_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic [nrc_pkg::STR_W-1:0]     cell_idx,
   input  logic [nrc_pkg::NUM_W-1:0]     num_in_use,
   input  nrc_pkg::token_type            tok_i,
   output nrc_pkg::token_type            tok_o
);

   logic [nrc_pkg::BASE_W-1:0] mem [nrc_pkg::MAX_LOCI];
   logic [nrc_pkg::BASE_W-1:0] rdata_ff;
   nrc_pkg::token_type         tok_a_ff;
   nrc_pkg::token_type         tok_o_ff, tok_o_in;
   logic [nrc_pkg::CNT_W-1:0]  cnt_ff, cnt_in, cnt_new;

   logic hit;
   logic fin;
   logic in_use;

   // first half: store access, data registered
   always_ff @(posedge clock) begin
      if (en) begin
         if (tok_i.valid && tok_i.load && tok_i.strain == cell_idx) begin
            mem[tok_i.addr] <= tok_i.base;
         end
         rdata_ff <= mem[tok_i.addr];
      end
   end

   // second half: compare, count, fold into running minimum
   always_comb begin
      hit = tok_a_ff.valid && tok_a_ff.count &&
            rdata_ff != nrc_pkg::BASE_N && rdata_ff != tok_a_ff.base;
      cnt_new = hit ? nrc_pkg::sat_inc(cnt_ff) : cnt_ff;
      fin     = tok_a_ff.valid && !tok_a_ff.load && tok_a_ff.last;
      in_use  = int'(cell_idx) < int'(num_in_use);

      tok_o_in = tok_a_ff;
      if (fin && in_use && (cell_idx == '0 || cnt_new < tok_a_ff.best_dist)) begin
         tok_o_in.best_dist = cnt_new;
         tok_o_in.best_idx  = nrc_pkg::NUM_W'(cell_idx);
      end
      cnt_in = fin ? '0 : cnt_new;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         tok_a_ff <= '0;
         tok_o_ff <= '0;
      end else if (en) begin
         cnt_ff   <= cnt_in;
         tok_a_ff <= tok_i;
         tok_o_ff <= tok_o_in;
      end
   end

   assign tok_o = tok_o_ff;

endmodule

@@ src/nrc_outq.sv @@
`timescale 1ns / 1ps

module nrc_outq (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  nrc_pkg::rsp_type push_data,
   input  logic             stall,
   output logic             valid,
   output nrc_pkg::rsp_type data,
   output logic             full
);

   logic [1:0]       cnt_ff, cnt_in;
   nrc_pkg::rsp_type slot0_ff, slot1_ff;
   logic             pop;

   assign valid = (cnt_ff != 2'd0);
   assign full  = (cnt_ff == 2'd2);
   assign data  = slot0_ff;
   assign pop   = valid && !stall;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_ff == 2'd2 && pop) begin
         slot0_ff <= slot1_ff;
      end else if ((cnt_ff == 2'd0 || (cnt_ff == 2'd1 && pop)) && push) begin
         slot0_ff <= push_data;
      end
      if (push && ((cnt_ff == 2'd1 && !pop) || (cnt_ff == 2'd2 && pop))) begin
         slot1_ff <= push_data;
      end
   end

endmodule

@@ src/nrc_checker.sv @@
`timescale 1ns / 1ps

module nrc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [3:0] rsp_best_strain,
   input logic [6:0] rsp_best_distance,
   input logic [6:0] rsp_unknown_count,
   input logic       rsp_too_long
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_best_strain) &&
      $stable(rsp_best_distance) && $stable(rsp_unknown_count) && $stable(rsp_too_long))
      else $error("stalled result changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("not idle after reset");

   // distance is bounded by the loci, or the empty-set marker
   a_dist_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(rsp_best_distance) <= nrc_pkg::MAX_LOCI ||
                    rsp_best_distance == nrc_pkg::CNT_MAX)
      else $error("best distance out of range");

   a_unknown_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(rsp_unknown_count) <= nrc_pkg::MAX_LOCI)
      else $error("unknown count out of range");

   a_strain_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(rsp_best_strain) <= nrc_pkg::MAX_STRAINS)
      else $error("best strain out of range");

endmodule

bind nearest_reference_classifier_unit nrc_checker u_nrc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_best_strain   (rsp_best_strain),
   .rsp_best_distance (rsp_best_distance),
   .rsp_unknown_count (rsp_unknown_count),
   .rsp_too_long      (rsp_too_long)
);

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_READ = 1'b1;
   localparam logic [7:0] BASE_A = 8'd65;
   localparam logic [7:0] BASE_C = 8'd67;
   localparam logic [7:0] BASE_G = 8'd71;
   localparam logic [7:0] BASE_T = 8'd84;
   localparam int CHAIN_LATENCY = 2 * nrc_pkg::MAX_STRAINS + 2;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_mode = 1'b0;
   logic [2:0] req_strain = '0;
   logic [5:0] req_locus = '0;
   logic [7:0] req_base = '0;
   logic req_last = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [3:0] rsp_best_strain;
   logic [6:0] rsp_best_distance;
   logic [6:0] rsp_unknown_count;
   logic rsp_too_long;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [nrc_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [nrc_pkg::CSR_DATA_W-1:0] csr_data = '0;

   nearest_reference_classifier_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_strain(req_strain), .req_locus(req_locus), .req_base(req_base),
      .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_best_strain(rsp_best_strain), .rsp_best_distance(rsp_best_distance),
      .rsp_unknown_count(rsp_unknown_count), .rsp_too_long(rsp_too_long),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // classifier state as seen from outside
   logic [7:0] ref_bases [nrc_pkg::MAX_STRAINS][nrc_pkg::MAX_LOCI];
   int mismatch_tally [nrc_pkg::MAX_STRAINS];
   int read_index;
   int n_tally;
   logic overlong;
   logic [3:0] num_strains_cfg = nrc_pkg::NUM_RESET;
   logic [6:0] threshold_cfg = nrc_pkg::THR_RESET;
   logic [7:0] consensus [nrc_pkg::MAX_LOCI];

   nrc_pkg::rsp_type expected_calls [$];
   nrc_pkg::rsp_type want;

   int errors = 0;
   int items_sent = 0;
   int reads_sent = 0;
   int results_checked = 0;
   int csr_writes = 0;
   int burst_left = 0;
   int cycle_count = 0;
   int stall_left = 0;
   int stall_style = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d calls outstanding", $time, expected_calls.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // receiver back-pressure: switches between random stall patterns
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_style <= $urandom_range(0, 3);
         stall_left <= $urandom_range(5, 60);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_style)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= 1'($urandom_range(0, 1));
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= cycle_count[2];
      endcase
   end

   task automatic check_field(input string field_name, input int exp_val, input int act_val);
      if (exp_val != act_val) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d",
                  $time, field_name, exp_val, act_val);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_calls.size() == 0) begin
            $display("%0t: unexpected transaction: strain %0d distance %0d",
                     $time, rsp_best_strain, rsp_best_distance);
            errors++;
         end else begin
            want = expected_calls.pop_front();
            check_field("best_strain", int'(want.best_strain), int'(rsp_best_strain));
            check_field("best_distance", int'(want.best_distance), int'(rsp_best_distance));
            check_field("unknown_count", int'(want.unknown_count), int'(rsp_unknown_count));
            check_field("too_long", int'(want.too_long), int'(rsp_too_long));
            results_checked++;
         end
      end
   end

   // advance the classifier state by one accepted item
   task automatic classify_step(input logic mode, input logic [2:0] strain,
                                input logic [5:0] locus, input logic [7:0] base,
                                input logic last);
      int s;
      int k;
      int best_idx;
      int best_dist;
      nrc_pkg::rsp_type call;
      if (mode == MODE_LOAD) begin
         ref_bases[strain][locus] = base;
      end else begin
         if (read_index >= nrc_pkg::MAX_LOCI) begin
            overlong = 1'b1;
         end else begin
            if (base == nrc_pkg::BASE_N) begin
               if (n_tally < int'(nrc_pkg::CNT_MAX)) n_tally++;
            end else begin
               for (s = 0; s < nrc_pkg::MAX_STRAINS; s++) begin
                  if (ref_bases[s][read_index] != nrc_pkg::BASE_N &&
                      ref_bases[s][read_index] != base)
                     if (mismatch_tally[s] < int'(nrc_pkg::CNT_MAX)) mismatch_tally[s]++;
               end
            end
            read_index++;
         end
         if (last) begin
            k = (int'(num_strains_cfg) > nrc_pkg::MAX_STRAINS) ?
                nrc_pkg::MAX_STRAINS : int'(num_strains_cfg);
            best_idx = k;
            best_dist = int'(nrc_pkg::CNT_MAX);
            for (s = 0; s < k; s++) begin
               if (s == 0 || mismatch_tally[s] < best_dist) begin
                  best_dist = mismatch_tally[s];
                  best_idx = s;
               end
            end
            if (k == 0 || best_dist >= int'(threshold_cfg)) best_idx = k;
            call.best_strain = 4'(best_idx);
            call.best_distance = 7'(best_dist);
            call.unknown_count = 7'(n_tally);
            call.too_long = overlong;
            expected_calls.insert(expected_calls.size(), call);
            for (s = 0; s < nrc_pkg::MAX_STRAINS; s++) mismatch_tally[s] = 0;
            read_index = 0;
            n_tally = 0;
            overlong = 1'b0;
         end
      end
   endtask

   // starts and ends at a falling edge; valid stays high inside a burst
   task automatic send_item(input logic mode, input logic [2:0] strain,
                            input logic [5:0] locus, input logic [7:0] base,
                            input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_mode <= mode;
      req_strain <= strain;
      req_locus <= locus;
      req_base <= base;
      req_last <= last;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      classify_step(mode, strain, locus, base, last);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_calls.size() != 0) @(negedge clock);
      // loads and partial reads leave no result but may still be in the chain
      repeat (CHAIN_LATENCY + 4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [nrc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [nrc_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      if (idx == nrc_pkg::CSR_NUM_STRAINS) num_strains_cfg = data[3:0];
      else if (idx == nrc_pkg::CSR_THRESHOLD) threshold_cfg = data;
      csr_writes++;
      @(negedge clock);
   endtask

   task automatic set_config(input logic [nrc_pkg::CSR_DATA_W-1:0] num_data,
                             input logic [nrc_pkg::CSR_DATA_W-1:0] thr_data);
      drain_results();
      write_csr(nrc_pkg::CSR_NUM_STRAINS, num_data);
      write_csr(nrc_pkg::CSR_THRESHOLD, thr_data);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [7:0] random_nucleotide();
      case ($urandom_range(0, 3))
         0: return BASE_A;
         1: return BASE_C;
         2: return BASE_G;
         default: return BASE_T;
      endcase
   endfunction

   function automatic logic [7:0] noise_base();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return random_nucleotide();
      if (r < 85) return nrc_pkg::BASE_N;
      return 8'($urandom_range(0, 255));
   endfunction

   // mostly a copy of one strain, with substitutions, unknowns and junk bytes
   function automatic logic [7:0] read_base(input int src, input int pos);
      int r;
      logic [7:0] b;
      if (pos >= nrc_pkg::MAX_LOCI) return noise_base();
      r = $urandom_range(0, 99);
      if (r < 82) begin
         b = ref_bases[src][pos];
         return (b == nrc_pkg::BASE_N) ? random_nucleotide() : b;
      end
      if (r < 92) return random_nucleotide();
      if (r < 96) return nrc_pkg::BASE_N;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_read(input int len, input int src);
      int p;
      for (p = 0; p < len; p++) begin
         // an occasional store update slipped into the middle of a read
         if ($urandom_range(0, 99) < 3)
            send_item(MODE_LOAD, 3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)),
                      noise_base(), 1'($urandom_range(0, 1)));
         send_item(MODE_READ, 3'($urandom), 6'($urandom), read_base(src, p), p == len - 1);
      end
      reads_sent++;
   endtask

   task automatic run_random_reads(input int n_items);
      int start;
      int r;
      int len;
      start = items_sent;
      while (items_sent - start < n_items) begin
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 4))
               send_item(MODE_LOAD, 3'($urandom), 6'($urandom), noise_base(),
                         1'($urandom_range(0, 1)));
         r = $urandom_range(0, 99);
         if (r < 65) len = $urandom_range(1, 8);
         else if (r < 88) len = $urandom_range(9, 40);
         else if (r < 94) len = $urandom_range(41, 64);
         else len = $urandom_range(63, 70);
         send_read(len, $urandom_range(0, nrc_pkg::MAX_STRAINS - 1));
      end
   endtask

   // every store entry is written before any read touches it
   task automatic test_fill_store();
      int s;
      int p;
      int r;
      logic [7:0] b;
      for (p = 0; p < nrc_pkg::MAX_LOCI; p++) consensus[p] = random_nucleotide();
      for (s = 0; s < nrc_pkg::MAX_STRAINS; s++) begin
         for (p = 0; p < nrc_pkg::MAX_LOCI; p++) begin
            r = $urandom_range(0, 99);
            if (r < 80) b = consensus[p];
            else if (r < 92) b = random_nucleotide();
            else if (r < 97) b = nrc_pkg::BASE_N;
            else b = 8'($urandom_range(0, 255));
            send_item(MODE_LOAD, 3'(s), 6'(p), b, 1'($urandom_range(0, 1)));
         end
      end
   endtask

   task automatic test_directed_cases();
      // store edges; last on a load must be ignored
      send_item(MODE_LOAD, 3'd0, 6'd0, BASE_A, 1'b1);
      send_item(MODE_LOAD, 3'd1, 6'd0, nrc_pkg::BASE_N, 1'b0);
      send_item(MODE_LOAD, 3'd7, 6'd63, 8'hFF, 1'b1);
      send_item(MODE_LOAD, 3'd2, 6'd1, 8'h00, 1'b0);
      // single unknown base: all distances zero
      send_item(MODE_READ, 3'd7, 6'd63, nrc_pkg::BASE_N, 1'b1);
      // strain 0 matches, strain 1 skipped: tie goes to the lower index
      send_item(MODE_READ, 3'd0, 6'd0, BASE_A, 1'b1);
      send_item(MODE_READ, 3'd0, 6'd0, 8'hFF, 1'b1);
      send_item(MODE_READ, 3'd0, 6'd0, 8'h00, 1'b1);
      send_item(MODE_READ, 3'd5, 6'd21, BASE_C, 1'b0);
      send_item(MODE_READ, 3'd2, 6'd42, 8'h00, 1'b0);
      send_item(MODE_READ, 3'd0, 6'd0, nrc_pkg::BASE_N, 1'b1);
      send_item(MODE_READ, 3'd0, 6'd0, consensus[0], 1'b0);
      send_item(MODE_READ, 3'd0, 6'd0, BASE_T, 1'b1);
   endtask

   task automatic test_long_read();
      send_read(64, $urandom_range(0, nrc_pkg::MAX_STRAINS - 1));
      send_read(65, $urandom_range(0, nrc_pkg::MAX_STRAINS - 1));
      send_read(70, $urandom_range(0, nrc_pkg::MAX_STRAINS - 1));
   endtask

   task automatic test_config_sweep();
      int i;
      logic [nrc_pkg::CSR_DATA_W-1:0] n;
      logic [nrc_pkg::CSR_DATA_W-1:0] t;
      for (i = 0; i < 10; i++) begin
         case (i)
            0: begin n = 7'd1;  t = 7'd0;   end
            1: begin n = 7'd8;  t = 7'd127; end
            2: begin n = 7'd0;  t = 7'd5;   end
            3: begin n = 7'h7F; t = 7'd3;   end
            4: begin n = 7'd9;  t = 7'd1;   end
            5: begin n = 7'd4;  t = 7'd65;  end
            6: begin n = 7'h78; t = 7'd2;   end
            default: begin
               n = 7'($urandom_range(0, 127));
               t = 7'($urandom_range(0, 8));
            end
         endcase
         set_config(n, t);
         run_random_reads(100);
      end
   endtask

   task automatic test_pause_and_resume();
      run_random_reads(60);
      drain_results();
      run_random_reads(60);
   endtask

   initial begin
      for (int s = 0; s < nrc_pkg::MAX_STRAINS; s++) mismatch_tally[s] = 0;
      read_index = 0;
      n_tally = 0;
      overlong = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_fill_store();
      test_directed_cases();
      run_random_reads(200);
      test_long_read();
      test_config_sweep();
      test_pause_and_resume();

      req_valid <= 1'b0;
      while (expected_calls.size() != 0) @(negedge clock);
      repeat (CHAIN_LATENCY + 10) @(negedge clock);

      $display("Sent %0d transactions: %0d reads, %0d results checked, %0d register writes",
               items_sent, reads_sent, results_checked, csr_writes);
      $display("Strain counts 0 to 15 and thresholds 0 to 127, overlong reads, mid-read loads");
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
